>>> rtl/tile_map_region_collision_core_defines.svh
// Assertion macros shared by the tile collision block.
`ifndef TILE_MAP_REGION_COLLISION_CORE_DEFINES_SVH
`define TILE_MAP_REGION_COLLISION_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// expects i_clk and i_rst_n in scope
`define TMRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define TMRC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define TMRC_ASSERT(lbl, prop, msg)
`define TMRC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/tmrc_pkg.sv
// Types and constants of the tile collision block.
package tmrc_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;
    localparam int QUEUE_DEPTH  = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int TS_W       = 8;
    localparam int MAP_W      = 7;
    // clamped bounds never exceed the 7-bit map size registers
    localparam int BND_W      = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd2;

    localparam logic [TS_W-1:0]  TILE_SIZE_RST  = 8'd32;
    localparam logic [MAP_W-1:0] MAP_WIDTH_RST  = 7'd64;
    localparam logic [MAP_W-1:0] MAP_HEIGHT_RST = 7'd64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // classified word handed from front to back
    typedef struct packed {
        logic             is_query;
        logic             none;     // nothing to touch: empty range or write off the grid
        logic             solid;
        logic [BND_W-1:0] col_lo;
        logic [BND_W-1:0] col_hi;
        logic [BND_W-1:0] row_lo;
        logic [BND_W-1:0] row_hi;
    } t_cmd;

endpackage

>>> rtl/tmrc_ram.sv
// Generic simple dual-port RAM with registered read.
module tmrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> rtl/tmrc_front.sv
// Front end: config registers, item intake, edge division and range classification.
`include "tile_map_region_collision_core_defines.svh"
module tmrc_front #(
    parameter int MAX_COLS = tmrc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tmrc_pkg::MAX_ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tmrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tmrc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_op,
    input  logic [5:0]                       i_tile_col,
    input  logic [5:0]                       i_tile_row,
    input  logic signed [15:0]               i_tile_value,
    input  logic signed [15:0]               i_rect_x,
    input  logic signed [15:0]               i_rect_y,
    input  logic [14:0]                      i_rect_w,
    input  logic [14:0]                      i_rect_h,
    input  logic                             i_clearing,
    output tmrc_pkg::t_cmd                   o_cmd,
    output logic                             o_cmd_valid,
    input  logic                             i_cmd_ready
);
    import tmrc_pkg::*;

    localparam int LANES   = 4;     // left, right, top, bottom
    localparam int SUM_W   = 17;
    localparam int NUM_W   = 20;
    localparam int DIV_BITS = 4;
    localparam int DIV_CYC = NUM_W / DIV_BITS;
    localparam int STEP_W  = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
    localparam int CAP_C   = (MAX_COLS < 127) ? MAX_COLS : 127;
    localparam int CAP_R   = (MAX_ROWS < 127) ? MAX_ROWS : 127;

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    t_fstate          r_state;
    logic [STEP_W-1:0] r_step;
    logic [TS_W-1:0]  r_tile_size;
    logic [MAP_W-1:0] r_map_width;
    logic [MAP_W-1:0] r_map_height;
    logic             r_is_query;
    t_cmd             r_wcmd;
    logic [TS_W-1:0]  r_div;
    logic [NUM_W-1:0] r_num [LANES];
    logic [TS_W-1:0]  r_rem [LANES];
    logic             r_neg [LANES];

    logic [NUM_W-1:0] n_num [LANES];
    logic [TS_W-1:0]  n_rem [LANES];
    logic [SUM_W-1:0] sum [LANES];
    logic [SUM_W-1:0] mag [LANES];
    logic [TS_W-1:0]  ts_eff;
    logic [MAP_W-1:0] cols;
    logic [MAP_W-1:0] rows;
    t_cmd             w_cmd;
    t_cmd             q_cmd;

    assign sum[0] = {i_rect_x[15], i_rect_x};
    assign sum[1] = {i_rect_x[15], i_rect_x} + {2'b00, i_rect_w};
    assign sum[2] = {i_rect_y[15], i_rect_y};
    assign sum[3] = {i_rect_y[15], i_rect_y} + {2'b00, i_rect_h};

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            mag[l] = sum[l][SUM_W-1] ? (~sum[l] + SUM_W'(1)) : sum[l];
        end
    end

    assign ts_eff = (r_tile_size == '0) ? TS_W'(1) : r_tile_size;

    // restoring division, DIV_BITS quotient bits per lane per cycle
    always_comb begin
        logic [TS_W-1:0]  rem;
        logic [NUM_W-1:0] num;
        logic [TS_W:0]    trial;
        logic             qb;
        for (int l = 0; l < LANES; l++) begin
            rem = r_rem[l];
            num = r_num[l];
            for (int b = 0; b < DIV_BITS; b++) begin
                trial = {rem, num[NUM_W-1]};
                if (trial >= {1'b0, r_div}) begin
                    rem = TS_W'(trial - {1'b0, r_div});
                    qb  = 1'b1;
                end else begin
                    rem = trial[TS_W-1:0];
                    qb  = 1'b0;
                end
                num = {num[NUM_W-2:0], qb};
            end
            n_rem[l] = rem;
            n_num[l] = num;
        end
    end

    always_comb begin
        w_cmd          = '0;
        w_cmd.is_query = 1'b0;
        w_cmd.none     = !((int'(i_tile_col) < MAX_COLS) && (int'(i_tile_row) < MAX_ROWS));
        w_cmd.solid    = (i_tile_value > 16'sd0);
        w_cmd.col_lo   = BND_W'(i_tile_col);
        w_cmd.row_lo   = BND_W'(i_tile_row);
    end

    assign cols = (r_map_width > MAP_W'(CAP_C)) ? MAP_W'(CAP_C) : r_map_width;
    assign rows = (r_map_height > MAP_W'(CAP_R)) ? MAP_W'(CAP_R) : r_map_height;

    always_comb begin
        q_cmd          = '0;
        q_cmd.is_query = 1'b1;
        q_cmd.none     = (cols == '0) || (rows == '0)
                      || (r_neg[1] && r_num[1] != '0) || (r_neg[3] && r_num[3] != '0)
                      || (!r_neg[0] && r_num[0] >= NUM_W'(cols))
                      || (!r_neg[2] && r_num[2] >= NUM_W'(rows));
        q_cmd.col_lo   = r_neg[0] ? '0 : r_num[0][BND_W-1:0];
        q_cmd.row_lo   = r_neg[2] ? '0 : r_num[2][BND_W-1:0];
        if (r_neg[1]) begin
            q_cmd.col_hi = '0;
        end else if (r_num[1] >= NUM_W'(cols)) begin
            q_cmd.col_hi = BND_W'(cols - MAP_W'(1));
        end else begin
            q_cmd.col_hi = r_num[1][BND_W-1:0];
        end
        if (r_neg[3]) begin
            q_cmd.row_hi = '0;
        end else if (r_num[3] >= NUM_W'(rows)) begin
            q_cmd.row_hi = BND_W'(rows - MAP_W'(1));
        end else begin
            q_cmd.row_hi = r_num[3][BND_W-1:0];
        end
    end

    assign o_ready     = (r_state == F_IDLE) && !i_clearing;
    assign o_cfg_ready = 1'b1;
    assign o_cmd_valid = (r_state == F_PUSH);
    assign o_cmd       = r_is_query ? q_cmd : r_wcmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= F_IDLE;
            r_step       <= '0;
            r_tile_size  <= TILE_SIZE_RST;
            r_map_width  <= MAP_WIDTH_RST;
            r_map_height <= MAP_HEIGHT_RST;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_TILE_SIZE:  r_tile_size  <= i_cfg_data[TS_W-1:0];
                    CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data[MAP_W-1:0];
                    CFG_MAP_HEIGHT: r_map_height <= i_cfg_data[MAP_W-1:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_is_query <= (i_op == OP_QUERY);
                        r_wcmd     <= w_cmd;
                        r_div      <= ts_eff;
                        r_step     <= '0;
                        for (int l = 0; l < LANES; l++) begin
                            r_num[l] <= NUM_W'(mag[l]);
                            r_rem[l] <= '0;
                            r_neg[l] <= sum[l][SUM_W-1];
                        end
                        r_state <= (i_op == OP_QUERY) ? F_DIV : F_PUSH;
                    end
                end
                F_DIV: begin
                    r_num  <= n_num;
                    r_rem  <= n_rem;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIV_CYC - 1)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (i_cmd_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    `TMRC_ASSERT(a_div_len, (r_state == F_PUSH && $past(r_state) == F_DIV) |-> r_is_query, "division ended on a write word")
endmodule

>>> rtl/tmrc_queue.sv
// Short word queue between front and back.
`include "tile_map_region_collision_core_defines.svh"
module tmrc_queue #(
    parameter int DEPTH = tmrc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tmrc_pkg::t_cmd i_cmd,
    input  logic           i_valid,
    output logic           o_ready,
    output tmrc_pkg::t_cmd o_cmd,
    output logic           o_valid,
    input  logic           i_ready
);
    import tmrc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    `TMRC_ASSERT_NEVER(a_q_over, r_cnt > CNT_W'(DEPTH), "queue fill beyond depth")
endmodule

>>> rtl/tmrc_back.sv
// Back end: mark store, clearing pass, tile write and row scan, result register.
`include "tile_map_region_collision_core_defines.svh"
module tmrc_back #(
    parameter int MAX_COLS = tmrc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tmrc_pkg::MAX_ROWS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tmrc_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    output logic           o_clearing,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_was_query,
    output logic           o_hit
);
    import tmrc_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_WRB, B_SCAN, B_TAIL, B_RES} t_bstate;

    t_bstate          r_state;
    logic [ROW_W-1:0] r_row;
    t_cmd             r_cmd;
    logic             r_hit;
    logic             r_pend;
    logic             r_out_valid;
    logic             r_out_query;
    logic             r_out_hit;

    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic [MAX_COLS-1:0] wr_data;
    logic                rd_en;
    logic [ROW_W-1:0]    rd_addr;
    logic [MAX_COLS-1:0] rd_data;
    logic [MAX_COLS-1:0] row_mask;
    logic [MAX_COLS-1:0] row_upd;
    logic                row_any;
    logic                out_free;

    tmrc_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS),
        .ADDR_W(ROW_W)
    ) u_marks (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            row_mask[c] = (c >= int'(r_cmd.col_lo)) && (c <= int'(r_cmd.col_hi));
        end
    end

    assign row_any = |(rd_data & row_mask);

    always_comb begin
        row_upd = rd_data;
        row_upd[COL_W'(r_cmd.col_lo)] = r_cmd.solid;
    end

    assign rd_en   = ((r_state == B_IDLE) && i_cmd_valid) || (r_state == B_SCAN);
    assign rd_addr = (r_state == B_SCAN) ? r_row : ROW_W'(i_cmd.row_lo);
    assign wr_en   = (r_state == B_CLEAR) || (r_state == B_WRB);
    assign wr_addr = (r_state == B_CLEAR) ? r_row : ROW_W'(r_cmd.row_lo);
    assign wr_data = (r_state == B_CLEAR) ? '0 : row_upd;

    assign out_free    = !r_out_valid || i_ready;
    assign o_cmd_ready = (r_state == B_IDLE);
    assign o_clearing  = (r_state == B_CLEAR);
    assign o_valid     = r_out_valid;
    assign o_was_query = r_out_query;
    assign o_hit       = r_out_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_row       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == B_RES) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLEAR: begin
                    if (r_row == ROW_W'(MAX_ROWS - 1)) begin
                        r_row   <= '0;
                        r_state <= B_IDLE;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end
                B_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd  <= i_cmd;
                        r_hit  <= 1'b0;
                        r_pend <= 1'b0;
                        r_row  <= ROW_W'(i_cmd.row_lo);
                        if (i_cmd.none) begin
                            r_state <= B_RES;
                        end else if (i_cmd.is_query) begin
                            r_state <= B_SCAN;
                        end else begin
                            r_state <= B_WRB;
                        end
                    end
                end
                B_WRB: r_state <= B_RES;
                B_SCAN: begin
                    if (r_pend && row_any) begin
                        r_hit <= 1'b1;
                    end
                    r_pend <= 1'b1;
                    if (r_row == ROW_W'(r_cmd.row_hi)) begin
                        r_state <= B_TAIL;
                    end else begin
                        r_row <= r_row + ROW_W'(1);
                    end
                end
                B_TAIL: begin
                    if (row_any) begin
                        r_hit <= 1'b1;
                    end
                    r_pend  <= 1'b0;
                    r_state <= B_RES;
                end
                B_RES: begin
                    if (out_free) begin
                        r_out_query <= r_cmd.is_query;
                        r_out_hit   <= r_hit;
                        r_state     <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `TMRC_ASSERT(a_wrb_after_rd, (r_state == B_WRB) |-> ($past(r_state) == B_IDLE), "write-back without row read")
    `TMRC_ASSERT(a_scan_bound, (r_state == B_SCAN) |-> (r_row <= ROW_W'(r_cmd.row_hi)), "scan ran past last row")
    `TMRC_ASSERT_NEVER(a_word_in_clear, (r_state == B_CLEAR) && i_cmd_valid, "word queued during clearing pass")
endmodule

>>> rtl/tile_map_region_collision_core.sv
// Top level of the tile map rectangle collision block.
//
// Input channel (i_valid/o_ready): one word per item. i_op low writes a tile mark at
// i_tile_col/i_tile_row, solid when i_tile_value is positive; i_op high queries the
// pixel rectangle i_rect_x/i_rect_y/i_rect_w/i_rect_h against the marks.
// Output channel (o_valid/i_ready): one word per item, o_was_query and o_hit.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 tile size,
// 1 map width, 2 map height; it is to be written only while the block is idle; the
// block itself does not enforce this. The front end's edge divider works four quotient
// bits per step and takes no new item until its classified word enters the queue; the
// back end reads one mark row per cycle, and a write is a read-modify-write of one row.
// Reset: the mark store is cleared one row per cycle, with o_ready low meanwhile;
// config returns to 32, 64, 64.
// A stalled receiver holds the result register; up to two classified words wait
// in the queue, then the front end stops accepting.
`include "tile_map_region_collision_core_defines.svh"
module tile_map_region_collision_core #(
    parameter int MAX_COLS = tmrc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tmrc_pkg::MAX_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tmrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tmrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [5:0]                      i_tile_col,
    input  logic [5:0]                      i_tile_row,
    input  logic signed [15:0]              i_tile_value,
    input  logic signed [15:0]              i_rect_x,
    input  logic signed [15:0]              i_rect_y,
    input  logic [14:0]                     i_rect_w,
    input  logic [14:0]                     i_rect_h,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_was_query,
    output logic                            o_hit
);
    import tmrc_pkg::*;

    t_cmd front_cmd;
    logic front_valid;
    logic front_ready;
    t_cmd back_cmd;
    logic back_valid;
    logic back_ready;
    logic clearing;

    tmrc_front #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_tile_col  (i_tile_col),
        .i_tile_row  (i_tile_row),
        .i_tile_value(i_tile_value),
        .i_rect_x    (i_rect_x),
        .i_rect_y    (i_rect_y),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .i_clearing  (clearing),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready)
    );

    tmrc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (front_cmd),
        .i_valid(front_valid),
        .o_ready(front_ready),
        .o_cmd  (back_cmd),
        .o_valid(back_valid),
        .i_ready(back_ready)
    );

    tmrc_back #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (back_cmd),
        .i_cmd_valid(back_valid),
        .o_cmd_ready(back_ready),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_was_query(o_was_query),
        .o_hit      (o_hit)
    );

    `TMRC_ASSERT_NEVER(a_no_intake_clear, clearing && o_ready, "intake open during clearing pass")
endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the tile map rectangle collision core.
`timescale 1ns / 100ps

module tb;
    import tmrc_pkg::*;

    localparam int GRID_COLS     = MAX_COLS_DEF;
    localparam int GRID_ROWS     = MAX_ROWS_DEF;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PRINT_CAP     = 50;

    typedef struct {
        logic               op;
        logic [5:0]         col;
        logic [5:0]         row;
        logic signed [15:0] value;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } tile_cmd_t;

    typedef struct {
        logic was_query;
        logic hit;
    } answer_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_op;
    logic [5:0]            i_tile_col;
    logic [5:0]            i_tile_row;
    logic signed [15:0]    i_tile_value;
    logic signed [15:0]    i_rect_x;
    logic signed [15:0]    i_rect_y;
    logic [14:0]           i_rect_w;
    logic [14:0]           i_rect_h;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_was_query;
    logic                  o_hit;

    // predictor state
    logic [GRID_COLS-1:0] mark_grid [GRID_ROWS];
    logic [TS_W-1:0]      cfg_tile_px;
    logic [MAP_W-1:0]     cfg_cols;
    logic [MAP_W-1:0]     cfg_rows;
    answer_t              pending_answers [$];

    int  errors;
    int  n_writes;
    int  n_queries;
    int  n_hits;
    int  n_cfg;
    int  n_answers;
    bit  tx_idle;
    bit  rx_idle;
    int  rx_hold;

    wire any_xfer = (i_valid && o_ready) || (o_valid && i_ready) ||
                    (i_cfg_valid && o_cfg_ready);

    tile_map_region_collision_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_tile_col   (i_tile_col),
        .i_tile_row   (i_tile_row),
        .i_tile_value (i_tile_value),
        .i_rect_x     (i_rect_x),
        .i_rect_y     (i_rect_y),
        .i_rect_w     (i_rect_w),
        .i_rect_h     (i_rect_h),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_was_query  (o_was_query),
        .o_hit        (o_hit)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic int eff_tile();
        return (cfg_tile_px == 0) ? 1 : int'(cfg_tile_px);
    endfunction

    function automatic int used_cols();
        return (cfg_cols < GRID_COLS) ? int'(cfg_cols) : GRID_COLS;
    endfunction

    function automatic int used_rows();
        return (cfg_rows < GRID_ROWS) ? int'(cfg_rows) : GRID_ROWS;
    endfunction

    function automatic logic region_hit(input tile_cmd_t c);
        int   ts;
        int   left;
        int   right;
        int   top;
        int   bottom;
        int   r;
        int   k;
        logic found;
        ts     = eff_tile();
        left   = int'(c.x) / ts;
        right  = (int'(c.x) + int'(c.w)) / ts;
        top    = int'(c.y) / ts;
        bottom = (int'(c.y) + int'(c.h)) / ts;
        if (left < 0) left = 0;
        if (top < 0) top = 0;
        if (right > used_cols() - 1) right = used_cols() - 1;
        if (bottom > used_rows() - 1) bottom = used_rows() - 1;
        found = 1'b0;
        for (r = top; r <= bottom; r++) begin
            for (k = left; k <= right; k++) begin
                found |= mark_grid[r][k];
            end
        end
        return found;
    endfunction

    // every field random, then shaped so most items land on or near the map
    function automatic tile_cmd_t random_cmd();
        tile_cmd_t c;
        int        ts;
        int        nc;
        int        nr;
        int        px;
        int        py;
        int        mode;
        c.op    = ($urandom_range(0, 9) < 4) ? OP_WRITE : OP_QUERY;
        c.col   = 6'($urandom);
        c.row   = 6'($urandom);
        c.value = 16'($urandom);
        c.x     = 16'($urandom);
        c.y     = 16'($urandom);
        c.w     = 15'($urandom);
        c.h     = 15'($urandom);
        ts = eff_tile();
        nc = (used_cols() > 0) ? used_cols() : 4;
        nr = (used_rows() > 0) ? used_rows() : 4;
        if (c.op == OP_WRITE) begin
            if ($urandom_range(0, 3) != 0) begin
                c.col = 6'($urandom_range(0, nc - 1));
                c.row = 6'($urandom_range(0, nr - 1));
            end
            if ($urandom_range(0, 3) == 0) begin
                c.value[15] = 1'b0;
                if (c.value == 0) c.value = 16'sd1;
            end else if ($urandom_range(0, 7) == 0) begin
                c.value = '0;
            end else begin
                c.value[15] = 1'b1;
            end
        end else begin
            mode = $urandom_range(0, 9);
            if (mode >= 1) begin
                px = (int'($urandom_range(0, nc + 2)) - 2) * ts + int'($urandom_range(0, ts - 1));
                py = (int'($urandom_range(0, nr + 2)) - 2) * ts + int'($urandom_range(0, ts - 1));
                c.x = px[15:0];
                c.y = py[15:0];
                if (mode >= 2) begin
                    c.w = 15'($urandom_range(0, 2 * ts));
                    c.h = 15'($urandom_range(0, 2 * ts));
                end
            end
        end
        return c;
    endfunction

    function automatic tile_cmd_t make_write(input int col, input int row, input int value);
        tile_cmd_t c;
        c       = random_cmd();
        c.op    = OP_WRITE;
        c.col   = col[5:0];
        c.row   = row[5:0];
        c.value = value[15:0];
        return c;
    endfunction

    function automatic tile_cmd_t make_query(input int x, input int y, input int w, input int h);
        tile_cmd_t c;
        c    = random_cmd();
        c.op = OP_QUERY;
        c.x  = x[15:0];
        c.y  = y[15:0];
        c.w  = w[14:0];
        c.h  = h[14:0];
        return c;
    endfunction

    task automatic send_cmd(input tile_cmd_t c);
        int      gap;
        answer_t a;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_op         <= c.op;
        i_tile_col   <= c.col;
        i_tile_row   <= c.row;
        i_tile_value <= c.value;
        i_rect_x     <= c.x;
        i_rect_y     <= c.y;
        i_rect_w     <= c.w;
        i_rect_h     <= c.h;
        do @(posedge i_clk); while (!(i_valid && o_ready));
        a.was_query = c.op;
        if (c.op == OP_QUERY) begin
            a.hit = region_hit(c);
            n_queries++;
            if (a.hit) n_hits++;
        end else begin
            // column and row are six bits, always inside storage
            mark_grid[c.row][c.col] = (c.value > 0);
            a.hit = 1'b0;
            n_writes++;
        end
        pending_answers.push_back(a);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_TILE_SIZE:  cfg_tile_px = data;
            CFG_MAP_WIDTH:  cfg_cols = data[MAP_W-1:0];
            CFG_MAP_HEIGHT: cfg_rows = data[MAP_W-1:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] ts, input logic [7:0] mw, input logic [7:0] mh);
        wait_idle();
        write_reg(CFG_TILE_SIZE, ts);
        write_reg(CFG_MAP_WIDTH, mw);
        write_reg(CFG_MAP_HEIGHT, mh);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_cmd(random_cmd());
    endtask

    task automatic test_reset_state();
        send_cmd(make_query(0, 0, 0, 0));
        send_cmd(make_query(0, 0, 32767, 32767));
        send_cmd(make_query(-32768, -32768, 32767, 32767));
        wait_idle();
    endtask

    // default setting: 32 pixel tiles, 64 x 64 map
    task automatic test_directed_cases();
        send_cmd(make_write(0, 0, 1));
        send_cmd(make_write(63, 63, 32767));
        send_cmd(make_write(10, 5, 0));
        send_cmd(make_write(11, 5, -32768));
        send_cmd(make_write(20, 30, -1));
        send_cmd(make_query(0, 0, 0, 0));
        send_cmd(make_query(2016, 2016, 0, 0));
        send_cmd(make_query(-33, -33, 32, 32));         // truncation toward zero keeps col 0
        send_cmd(make_query(-64, 0, 31, 0));            // right edge left of the map
        send_cmd(make_query(2048, 0, 100, 100));        // left edge past the last column
        send_cmd(make_query(0, 2048, 100, 100));        // top edge past the last row
        send_cmd(make_query(32767, 32767, 32767, 32767));
        send_cmd(make_query(-32768, -32768, 32767, 32767));
        send_cmd(make_query(320, 160, 63, 0));          // zero and negative values not solid
        send_cmd(make_query(640, 960, 0, 0));
        send_cmd(make_query(32, 32, 32767, 32767));     // clamped to last column and row
        send_cmd(make_write(0, 0, 0));
        send_cmd(make_write(63, 63, -1));
        send_cmd(make_query(-32768, -32768, 32767, 32767));
        send_cmd(make_query(0, 0, 32767, 32767));
        wait_idle();
    endtask

    task automatic test_register_extremes();
        apply_setting(8'd0, 8'd64, 8'd64);              // zero tile size acts as one
        send_random(20);
        apply_setting(8'd1, 8'd1, 8'd1);
        send_random(20);
        apply_setting(8'd255, 8'd64, 8'd64);
        send_random(20);
        apply_setting(8'd255, 8'd127, 8'd127);          // beyond storage
        send_random(20);
        apply_setting(8'd8, 8'd0, 8'd64);               // no columns
        send_random(20);
        apply_setting(8'd8, 8'd64, 8'd0);               // no rows
        send_random(20);
        apply_setting(8'd4, 8'd65, 8'd100);
        send_random(20);
        apply_setting(8'd16, 8'h85, 8'h83);             // upper data bit dropped
        send_cmd(make_write(50, 50, 1));                // stored outside the map in use
        send_cmd(make_query(800, 800, 0, 0));
        send_random(20);
        apply_setting(8'd32, 8'd64, 8'd64);
        send_cmd(make_query(1600, 1600, 0, 0));
        send_random(20);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        rx_hold = 400;
        send_random(40);
        wait_idle();
        tx_idle = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_random(30);
        wait_idle();
        send_random(30);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [7:0] ts;
        logic [7:0] mw;
        logic [7:0] mh;
        for (int phase = 0; phase < 10; phase++) begin
            ts = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 16)) : 8'($urandom);
            mw = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 64)) : 8'($urandom);
            mh = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 64)) : 8'($urandom);
            apply_setting(ts, mw, mh);
            tx_idle = (phase % 3) != 1;
            rx_idle = (phase % 3) != 2;
            send_random(100);
        end
        wait_idle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial begin : receiver
        int gap;
        i_ready = 1'b0;
        forever begin
            gap = rx_idle ? $urandom_range(0, 7) : 0;
            if (rx_hold > 0) begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            repeat (gap) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    initial begin : answer_monitor
        answer_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                n_answers++;
                if (pending_answers.size() == 0) begin
                    report_mismatch($sformatf("answer word with nothing pending, was_query=%b hit=%b",
                                              o_was_query, o_hit));
                end else begin
                    want = pending_answers.pop_front();
                    if (o_was_query !== want.was_query) begin
                        report_mismatch($sformatf("was_query got %b want %b",
                                                  o_was_query, want.was_query));
                    end
                    if (o_hit !== want.hit) begin
                        report_mismatch($sformatf("hit got %b want %b (was_query %b)",
                                                  o_hit, want.hit, want.was_query));
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if (any_xfer) stall = 0;
            else stall++;
        end
        $display("[%0t] no word moved for %0d cycles", $realtime, STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_op         = OP_WRITE;
        i_tile_col   = '0;
        i_tile_row   = '0;
        i_tile_value = '0;
        i_rect_x     = '0;
        i_rect_y     = '0;
        i_rect_w     = '0;
        i_rect_h     = '0;
        errors       = 0;
        n_writes     = 0;
        n_queries    = 0;
        n_hits       = 0;
        n_cfg        = 0;
        n_answers    = 0;
        tx_idle      = 1'b1;
        rx_idle      = 1'b1;
        rx_hold      = 0;
        cfg_tile_px  = TILE_SIZE_RST;
        cfg_cols     = MAP_WIDTH_RST;
        cfg_rows     = MAP_HEIGHT_RST;
        for (int r = 0; r < GRID_ROWS; r++) mark_grid[r] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_cases();
        test_register_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();
        wait_idle();

        $display("Covered %0d tile writes and %0d rectangle queries (%0d hits), %0d answers checked",
                 n_writes, n_queries, n_hits, n_answers);
        $display("%0d register writes across tile sizes 0..255 and map sizes 0..127, stalls both sides",
                 n_cfg);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
